// ===== src/three_channel_sync_root_counter_core_defines.svh =====
// Assertion macros for the root counter checker.
// Included by the checker file only.
`ifndef THREE_CHANNEL_SYNC_ROOT_COUNTER_CORE_DEFINES_SVH
`define THREE_CHANNEL_SYNC_ROOT_COUNTER_CORE_DEFINES_SVH
`define RC_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("root counter check failed");
`define RC_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("root counter check failed");
`endif

// ===== src/rcnt_pkg.sv =====
// Shared types and constants for the root counter block.
// No dependencies.
package rcnt_pkg;
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_TICK  = 3'd2;
    localparam logic [2:0] CMD_HBS   = 3'd3;
    localparam logic [2:0] CMD_HBE   = 3'd4;
    localparam logic [2:0] CMD_VBS   = 3'd5;
    localparam logic [2:0] CMD_VBE   = 3'd6;
    localparam logic [1:0] REG_VALUE  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;
    localparam logic CFG_DOT = 1'b0;
    localparam logic CFG_CPI = 1'b1;
    localparam int PULSE_CYCLES = 16;
    localparam logic [31:0] DOT_256 = 32'(65536 * 11 / 7 / 10);
    localparam logic [31:0] DOT_320 = 32'(65536 * 11 / 7 / 8);
    localparam logic [31:0] DOT_368 = 32'(65536 * 11 / 7 / 7);
    localparam logic [31:0] DOT_512 = 32'(65536 * 11 / 7 / 5);
    localparam logic [31:0] DOT_640 = 32'(65536 * 11 / 7 / 4);
    localparam logic [31:0] DOT_OTHER = 32'h0000_4000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  timer_select;
        logic [1:0]  reg_select;
        logic [15:0] write_data;
        logic [7:0]  elapsed_cycles;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [2:0]  irq_raise;
        logic        access_error;
    } out_item_t;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] mode;
        logic [15:0] target;
        logic [31:0] frac;
        logic [1:0]  delay;
        logic        pend;
        logic        paused;
        logic        armed;
        logic [8:0]  pulse;
    } chan_t;

    typedef struct packed {
        chan_t ch;
        logic  raised;
    } adv_t;

    function automatic logic [31:0] dot_step(input logic [2:0] sel);
        case (sel)
            3'd0: dot_step = DOT_256;
            3'd1: dot_step = DOT_320;
            3'd2: dot_step = DOT_368;
            3'd3: dot_step = DOT_512;
            default: dot_step = DOT_640;
        endcase
    endfunction
endpackage

// ===== src/rcnt_advance.sv =====
// Count advance of one counter: saturation, target match and irq logic.
// Depends on rcnt_pkg.
module rcnt_advance
    import rcnt_pkg::*;
(
    input  chan_t       ch_in,
    input  logic        en,
    input  logic [16:0] delta,
    input  logic [1:0]  idx,
    output adv_t        res
);
    logic [17:0] v;
    logic [15:0] m;
    logic        irq;
    logic [15:0] vv;

    always_comb
    begin
        res.ch     = ch_in;
        res.raised = 1'b0;
        m   = ch_in.mode;
        irq = 1'b0;
        v   = {2'b0, ch_in.value} + {1'b0, delta};
        vv  = v[15:0];
        if (en && !ch_in.paused)
        begin
            if (v >= 18'h0FFFF)
            begin
                m[12] = 1'b1;
                vv = 16'hFFFF;
                res.ch.pend = 1'b1;
                if (m[5])
                    irq = ch_in.armed;
            end
            if (ch_in.value < ch_in.target && v >= {2'b0, ch_in.target})
            begin
                m[11] = 1'b1;
                vv = ch_in.target;
                if (m[3])
                    res.ch.pend = 1'b1;
                if (m[4])
                    irq = ch_in.armed;
            end
            res.ch.value = vv;
            if (irq)
            begin
                if (m[7])
                begin
                    if (m[10])
                    begin
                        m[10] = 1'b0;
                        res.raised = 1'b1;
                    end
                    else
                        m[10] = 1'b1;
                end
                else
                begin
                    m[10] = 1'b0;
                    res.raised = 1'b1;
                    res.ch.pulse = 9'(PULSE_CYCLES);
                end
                if (!m[6])
                    res.ch.armed = 1'b0;
            end
            res.ch.mode = m;
        end
        if (idx == 2'd3)
            res.raised = 1'b0;
    end
endmodule

// ===== src/three_channel_sync_root_counter_core.sv =====
// Top level of the three-channel root counter block.
// Depends on rcnt_pkg and rcnt_advance.
//
// Usage:
// - in/in_valid/in_ready carry one item: a register write or read, a tick
//   of elapsed system cycles, or an hblank/vblank edge.
// - out/out_valid/out_ready return one result item per input item:
//   read data, irq bits raised and an access error flag.
// - cfg_we/cfg_index/cfg_data set the dot clock select and the cycles per
//   instruction; write them only while the block is idle.
// Output: the result is registered as the item is accepted.
// Throughput: one item per cycle while out_ready holds; the counter state updates in one pass
// of combinational logic between the accepted item and the state and
// result registers.
// Reset: all counters, modes and targets clear, hb_reg is set, config
// returns to dot select 1 and a cycles-per-instruction value of 2.
// Stall: while out_valid waits on out_ready, a new item is taken only if
// the result register frees in the same cycle; state never runs ahead.
module three_channel_sync_root_counter_core
    import rcnt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [3:0] cfg_data
);
    chan_t     ch_reg [3];
    chan_t     ch_next [3];
    chan_t     g [3];
    logic      hb_reg, hb_next, vb_reg, vb_next;
    logic [2:0] dot_reg;
    logic [3:0] cpi_reg;
    out_item_t out_reg, out_next;
    logic      ov_reg;
    logic      take;
    logic      gate [3];
    logic [31:0] f0, f2, step;
    logic [16:0] d0, d1, d2;
    logic        e0, e1, e2;
    adv_t      a0, a1, a2;
    logic [1:0] sm;
    logic [7:0] cyc;

    assign in_ready  = !ov_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out       = out_reg;
    assign cyc       = in.elapsed_cycles;

    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            g[t] = ch_reg[t];
            gate[t] = 1'b0;
            if (ch_reg[t].pend)
            begin
                g[t].value = '0;
                g[t].pend = 1'b0;
                if (ch_reg[t].mode[3])
                    g[t].delay = 2'd1;
            end
            else if (ch_reg[t].delay != 2'd0)
                g[t].delay = ch_reg[t].delay - 2'd1;
            else
                gate[t] = 1'b1;
        end
        step = (dot_reg < 3'd5) ? 32'({28'b0, cpi_reg} * dot_step(dot_reg)) : DOT_OTHER;
        f0 = g[0].frac + step;
        f2 = g[2].frac + {24'b0, cyc};
        if (!ch_reg[0].mode[8])
        begin
            d0 = {9'b0, cyc};
            e0 = gate[0];
        end
        else
        begin
            d0 = f0[31:16] == 16'h0 ? 17'd0 : {1'b0, f0[31:16]};
            e0 = gate[0] && (f0[31:16] != 16'h0);
        end
        if (in.cmd == CMD_TICK)
        begin
            d1 = {9'b0, cyc};
            e1 = gate[1] && !ch_reg[1].mode[8];
        end
        else
        begin
            d1 = 17'd1;
            e1 = (in.cmd == CMD_HBS) && ch_reg[1].mode[8];
        end
        if (!ch_reg[2].mode[9])
        begin
            d2 = {9'b0, cyc};
            e2 = gate[2];
        end
        else
        begin
            d2 = {4'b0, f2[31:3]} > 17'h1FFFF ? 17'h1FFFF : 17'(f2[31:3]);
            e2 = gate[2] && (f2[31:3] != 29'h0);
        end
    end

    rcnt_advance u_adv0 (.ch_in(g[0]), .en(e0 && in.cmd == CMD_TICK), .delta(d0),
                         .idx(2'd0), .res(a0));
    rcnt_advance u_adv1 (.ch_in(in.cmd == CMD_TICK ? g[1] : ch_reg[1]), .en(e1),
                         .delta(d1), .idx(2'd1), .res(a1));
    rcnt_advance u_adv2 (.ch_in(g[2]), .en(e2 && in.cmd == CMD_TICK), .delta(d2),
                         .idx(2'd2), .res(a2));

    always_comb
    begin
        for (int t = 0; t < 3; t++)
            ch_next[t] = ch_reg[t];
        hb_next = hb_reg;
        vb_next = vb_reg;
        out_next = '0;
        sm = 2'd0;
        case (in.cmd)
            CMD_WRITE, CMD_READ:
            begin
                if (in.timer_select == 2'd3 || in.reg_select == 2'd3)
                    out_next.access_error = 1'b1;
                else if (in.cmd == CMD_WRITE)
                begin
                    unique case (in.reg_select)
                        REG_VALUE:
                        begin
                            ch_next[in.timer_select].value = in.write_data;
                            ch_next[in.timer_select].delay = 2'd2;
                            ch_next[in.timer_select].pend = 1'b0;
                        end
                        REG_MODE:
                        begin
                            ch_next[in.timer_select].mode = {3'b0,
                                ch_reg[in.timer_select].mode[12:11], 1'b1,
                                in.write_data[9:0]};
                            ch_next[in.timer_select].value = '0;
                            ch_next[in.timer_select].frac = '0;
                            ch_next[in.timer_select].delay = 2'd2;
                            ch_next[in.timer_select].pend = 1'b0;
                            ch_next[in.timer_select].armed = 1'b1;
                            ch_next[in.timer_select].pulse = '0;
                            sm = in.write_data[2:1];
                            if (!in.write_data[0])
                                ch_next[in.timer_select].paused = 1'b0;
                            else if (in.timer_select == 2'd2)
                                ch_next[2].paused = (sm == 2'd0 || sm == 2'd3);
                            else
                                ch_next[in.timer_select].paused =
                                    (sm == 2'd0) ? (in.timer_select == 2'd0 ? hb_reg : vb_reg) :
                                    (sm == 2'd1) ? 1'b0 :
                                    (sm == 2'd2) ? !(in.timer_select == 2'd0 ? hb_reg : vb_reg) :
                                    1'b1;
                        end
                        default:
                            ch_next[in.timer_select].target = in.write_data;
                    endcase
                end
                else
                begin
                    unique case (in.reg_select)
                        REG_VALUE:  out_next.read_data = ch_reg[in.timer_select].value;
                        REG_MODE:
                        begin
                            out_next.read_data = ch_reg[in.timer_select].mode;
                            ch_next[in.timer_select].mode[12:11] = 2'b00;
                        end
                        default:    out_next.read_data = ch_reg[in.timer_select].target;
                    endcase
                end
            end
            CMD_TICK:
            begin
                ch_next[0] = a0.ch;
                ch_next[1] = a1.ch;
                ch_next[2] = a2.ch;
                if (gate[0] && ch_reg[0].mode[8])
                    ch_next[0].frac = {16'b0, f0[15:0]};
                if (gate[2] && ch_reg[2].mode[9])
                    ch_next[2].frac = {29'b0, f2[2:0]};
                out_next.irq_raise = {a2.raised, a1.raised, a0.raised};
                for (int t = 0; t < 3; t++)
                begin
                    if (ch_next[t].pulse != 9'd0)
                    begin
                        if ({1'b0, cyc} >= ch_next[t].pulse)
                        begin
                            ch_next[t].pulse = '0;
                            ch_next[t].mode[10] = 1'b1;
                        end
                        else
                            ch_next[t].pulse = ch_next[t].pulse - {1'b0, cyc};
                    end
                end
            end
            CMD_HBS:
            begin
                if (ch_reg[0].mode[0])
                begin
                    unique case (ch_reg[0].mode[2:1])
                        2'd0: ch_next[0].paused = 1'b1;
                        2'd1: ch_next[0].value = '0;
                        2'd2:
                        begin
                            ch_next[0].value = '0;
                            ch_next[0].paused = 1'b0;
                        end
                        default: ch_next[0].paused = 1'b0;
                    endcase
                end
                ch_next[1] = a1.ch;
                out_next.irq_raise = {1'b0, a1.raised, 1'b0};
                hb_next = 1'b1;
            end
            CMD_HBE:
            begin
                if (ch_reg[0].mode[0])
                begin
                    if (ch_reg[0].mode[2:1] == 2'd0)
                        ch_next[0].paused = 1'b0;
                    else if (ch_reg[0].mode[2:1] == 2'd2)
                        ch_next[0].paused = 1'b1;
                end
                hb_next = 1'b0;
            end
            CMD_VBS:
            begin
                if (ch_reg[1].mode[0])
                begin
                    unique case (ch_reg[1].mode[2:1])
                        2'd0: ch_next[1].paused = 1'b1;
                        2'd1:
                        begin
                            ch_next[1].value = '0;
                            ch_next[1].frac = '0;
                        end
                        2'd2:
                        begin
                            ch_next[1].value = '0;
                            ch_next[1].frac = '0;
                            ch_next[1].paused = 1'b0;
                        end
                        default: ch_next[1].paused = 1'b0;
                    endcase
                end
                vb_next = 1'b1;
            end
            CMD_VBE:
            begin
                if (ch_reg[1].mode[0])
                begin
                    if (ch_reg[1].mode[2:1] == 2'd0)
                        ch_next[1].paused = 1'b0;
                    else if (ch_reg[1].mode[2:1] == 2'd2)
                        ch_next[1].paused = 1'b1;
                end
                vb_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < 3; t++)
                ch_reg[t] <= '0;
            hb_reg  <= 1'b1;
            vb_reg  <= 1'b0;
            dot_reg <= 3'd1;
            cpi_reg <= 4'd2;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                for (int t = 0; t < 3; t++)
                    ch_reg[t] <= ch_next[t];
                hb_reg <= hb_next;
                vb_reg <= vb_next;
                ov_reg <= 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_DOT)
                    dot_reg <= cfg_data[2:0];
                else
                    cpi_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end
endmodule

// ===== src/rcnt_checker.sv =====
// Port-level checker for the root counter block, with its bind.
// Depends on rcnt_pkg and the defines header.
`include "three_channel_sync_root_counter_core_defines.svh"
module rcnt_checker
    import rcnt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out
);
    `RC_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)
    `RC_ASSERT_IMPL(a_ready_when_free, !out_valid, in_ready)
    `RC_ASSERT_NEXT(a_err_only_access,
        in_valid && in_ready && in.cmd != CMD_WRITE && in.cmd != CMD_READ,
        !out.access_error)
    `RC_ASSERT_NEXT(a_read_zero_nonread,
        in_valid && in_ready && in.cmd != CMD_READ, out.read_data == 16'h0)
endmodule

bind three_channel_sync_root_counter_core rcnt_checker u_rcnt_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in(in),
    .out_valid(out_valid), .out_ready(out_ready), .out(out)
);

// ===== tb/sv/tb_three_channel_sync_root_counter_core.sv =====
`timescale 1ns / 1ps
// Testbench for three_channel_sync_root_counter_core: directed rows, then random
// register accesses, ticks and blank edges checked against a behavioral predictor.
// Depends on rcnt_pkg and the core RTL.
module tb_three_channel_sync_root_counter_core;
    import rcnt_pkg::*;

    localparam int NUM_CNT = 3;
    localparam int PHASE_ITEMS = 270;
    localparam int IDLE_LIMIT = 1000;
    localparam int LONG_HOLD = 60;
    localparam logic [15:0] MB_SYNC_EN    = 16'h0001;
    localparam logic [15:0] MB_RST_TGT    = 16'h0008;
    localparam logic [15:0] MB_IRQ_TGT    = 16'h0010;
    localparam logic [15:0] MB_IRQ_FFFF   = 16'h0020;
    localparam logic [15:0] MB_REPEAT     = 16'h0040;
    localparam logic [15:0] MB_TOGGLE     = 16'h0080;
    localparam logic [15:0] MB_SRC0       = 16'h0100;
    localparam logic [15:0] MB_SRC1       = 16'h0200;
    localparam logic [15:0] MB_IRQ_LINE   = 16'h0400;
    localparam logic [15:0] MB_REACH_TGT  = 16'h0800;
    localparam logic [15:0] MB_REACH_FFFF = 16'h1000;
    localparam logic [31:0] DOT_TAB [5] = '{DOT_256, DOT_320, DOT_368, DOT_512, DOT_640};

    typedef struct {
        in_item_t  it;
        bit        fixed;
        out_item_t res;
    } dir_row_t;

    typedef struct {
        bit        fixed;
        out_item_t res;
    } typed_res_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   din;
    logic       out_valid;
    logic       out_ready;
    out_item_t  dout;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;

    logic [15:0] cval [NUM_CNT];
    logic [15:0] cmode [NUM_CNT];
    logic [15:0] ctgt [NUM_CNT];
    logic [31:0] frac [NUM_CNT];
    logic [1:0]  wait_left [NUM_CNT];
    bit          pend [NUM_CNT];
    bit          paused [NUM_CNT];
    bit          armed [NUM_CNT];
    logic [8:0]  pulse [NUM_CNT];
    bit          hbl;
    bit          vbl;
    logic [2:0]  dot_sel;
    logic [3:0]  cpi;

    out_item_t  result_q [$];
    typed_res_t typed_q [$];
    int         errors = 0;
    int         idle_cyc = 0;
    bit         calm = 0;
    bit         hold_req = 0;

    three_channel_sync_root_counter_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in(din),
        .out_valid(out_valid), .out_ready(out_ready), .out(dout),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void clear_model();
        for (int t = 0; t < NUM_CNT; t++)
        begin
            cval[t] = '0;
            cmode[t] = '0;
            ctgt[t] = '0;
            frac[t] = '0;
            wait_left[t] = '0;
            pend[t] = 0;
            paused[t] = 0;
            armed[t] = 0;
            pulse[t] = '0;
        end
        hbl = 1;
        vbl = 0;
        dot_sel = 3'd1;
        cpi = 4'd2;
    endfunction

    function automatic logic [2:0] count_up(int t, logic [31:0] delta);
        logic [31:0] prev;
        logic [31:0] v;
        logic [15:0] m;
        bit          irq;
        logic [2:0]  raised;
        irq = 0;
        raised = '0;
        if (paused[t])
            return '0;
        prev = {16'b0, cval[t]};
        v = prev + delta;
        m = cmode[t];
        if (v >= 32'h0000_FFFF)
        begin
            m |= MB_REACH_FFFF;
            v = 32'h0000_FFFF;
            pend[t] = 1;
            if (m & MB_IRQ_FFFF)
                irq = armed[t];
        end
        if (prev < {16'b0, ctgt[t]} && v >= {16'b0, ctgt[t]})
        begin
            m |= MB_REACH_TGT;
            v = {16'b0, ctgt[t]};
            if (m & MB_RST_TGT)
                pend[t] = 1;
            if (m & MB_IRQ_TGT)
                irq = armed[t];
        end
        cval[t] = v[15:0];
        if (irq)
        begin
            if (m & MB_TOGGLE)
            begin
                if (m & MB_IRQ_LINE)
                begin
                    m &= ~MB_IRQ_LINE;
                    raised = 3'b001 << t;
                end
                else
                    m |= MB_IRQ_LINE;
            end
            else
            begin
                m &= ~MB_IRQ_LINE;
                raised = 3'b001 << t;
                pulse[t] = 9'(PULSE_CYCLES);
            end
            if (!(m & MB_REPEAT))
                armed[t] = 0;
        end
        cmode[t] = m;
        return raised;
    endfunction

    function automatic bit may_count(int t);
        if (pend[t])
        begin
            cval[t] = '0;
            pend[t] = 0;
            if (cmode[t] & MB_RST_TGT)
                wait_left[t] = 2'd1;
            return 0;
        end
        if (wait_left[t] > 0)
        begin
            wait_left[t]--;
            return 0;
        end
        return 1;
    endfunction

    function automatic logic [2:0] tick_counters(logic [7:0] cycles);
        logic [2:0]  raised;
        logic [31:0] stp;
        logic [31:0] n;
        raised = '0;
        if (may_count(0))
        begin
            if (!(cmode[0] & MB_SRC0))
                raised |= count_up(0, {24'b0, cycles});
            else
            begin
                stp = (dot_sel < 3'd5) ? {28'b0, cpi} * DOT_TAB[dot_sel] : DOT_OTHER;
                frac[0] += stp;
                n = frac[0] >> 16;
                if (n > 0)
                begin
                    raised |= count_up(0, n);
                    frac[0] -= n << 16;
                end
            end
        end
        if (may_count(1))
        begin
            if (!(cmode[1] & MB_SRC0))
                raised |= count_up(1, {24'b0, cycles});
        end
        if (may_count(2))
        begin
            if (!(cmode[2] & MB_SRC1))
                raised |= count_up(2, {24'b0, cycles});
            else
            begin
                frac[2] += {24'b0, cycles};
                n = frac[2] >> 3;
                if (n > 0)
                begin
                    raised |= count_up(2, n);
                    frac[2] -= n << 3;
                end
            end
        end
        for (int t = 0; t < NUM_CNT; t++)
        begin
            if (pulse[t] > 0)
            begin
                if ({1'b0, cycles} >= pulse[t])
                begin
                    pulse[t] = '0;
                    cmode[t] |= MB_IRQ_LINE;
                end
                else
                    pulse[t] -= {1'b0, cycles};
            end
        end
        return raised;
    endfunction

    function automatic void load_mode(int t, logic [15:0] data);
        logic [1:0] sm;
        bit         blank;
        cmode[t] = (data & 16'h03FF) | MB_IRQ_LINE |
                   (cmode[t] & (MB_REACH_TGT | MB_REACH_FFFF));
        cval[t] = '0;
        frac[t] = '0;
        wait_left[t] = 2'd2;
        pend[t] = 0;
        sm = cmode[t][2:1];
        blank = (t == 0) ? hbl : vbl;
        if (cmode[t] & MB_SYNC_EN)
        begin
            if (t == 2)
                paused[t] = (sm == 2'd0 || sm == 2'd3);
            else
                case (sm)
                    2'd0: paused[t] = blank;
                    2'd1: paused[t] = 0;
                    2'd2: paused[t] = !blank;
                    default: paused[t] = 1;
                endcase
        end
        else
            paused[t] = 0;
        armed[t] = 1;
        pulse[t] = '0;
    endfunction

    function automatic void blank_start(int t);
        if (cmode[t] & MB_SYNC_EN)
            case (cmode[t][2:1])
                2'd0: paused[t] = 1;
                2'd1:
                begin
                    cval[t] = '0;
                    if (t == 1)
                        frac[t] = '0;
                end
                2'd2:
                begin
                    cval[t] = '0;
                    if (t == 1)
                        frac[t] = '0;
                    paused[t] = 0;
                end
                default: paused[t] = 0;
            endcase
    endfunction

    function automatic void blank_end(int t);
        if (cmode[t] & MB_SYNC_EN)
        begin
            if (cmode[t][2:1] == 2'd0)
                paused[t] = 0;
            else if (cmode[t][2:1] == 2'd2)
                paused[t] = 1;
        end
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t r;
        int        t;
        r = '0;
        t = int'(it.timer_select);
        case (it.cmd)
            CMD_WRITE, CMD_READ:
            begin
                if (t >= NUM_CNT || !(it.reg_select inside {REG_VALUE, REG_MODE, REG_TARGET}))
                    r.access_error = 1'b1;
                else if (it.cmd == CMD_WRITE)
                    case (it.reg_select)
                        REG_VALUE:
                        begin
                            cval[t] = it.write_data;
                            wait_left[t] = 2'd2;
                            pend[t] = 0;
                        end
                        REG_MODE: load_mode(t, it.write_data);
                        default: ctgt[t] = it.write_data;
                    endcase
                else
                    case (it.reg_select)
                        REG_VALUE: r.read_data = cval[t];
                        REG_MODE:
                        begin
                            r.read_data = cmode[t];
                            cmode[t] &= ~(MB_REACH_TGT | MB_REACH_FFFF);
                        end
                        default: r.read_data = ctgt[t];
                    endcase
            end
            CMD_TICK: r.irq_raise = tick_counters(it.elapsed_cycles);
            CMD_HBS:
            begin
                blank_start(0);
                if (cmode[1] & MB_SRC0)
                    r.irq_raise = count_up(1, 32'd1);
                hbl = 1;
            end
            CMD_HBE:
            begin
                blank_end(0);
                hbl = 0;
            end
            CMD_VBS:
            begin
                blank_start(1);
                vbl = 1;
            end
            CMD_VBE:
            begin
                blank_end(1);
                vbl = 0;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    function automatic in_item_t mk(logic [2:0] c, logic [1:0] ts, logic [1:0] rs,
                                    logic [15:0] d, logic [7:0] cyc);
        in_item_t it;
        it.cmd = c;
        it.timer_select = ts;
        it.reg_select = rs;
        it.write_data = d;
        it.elapsed_cycles = cyc;
        return it;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int       r;
        it = in_item_t'($urandom);
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            it.cmd = CMD_TICK;
            if ($urandom_range(0, 1))
                it.elapsed_cycles = 8'($urandom_range(0, 15));
        end
        else if (r < 55)
        begin
            it.cmd = CMD_READ;
            it.timer_select = 2'($urandom_range(0, 2));
            it.reg_select = 2'($urandom_range(0, 2));
        end
        else if (r < 72)
        begin
            it.cmd = CMD_WRITE;
            it.timer_select = 2'($urandom_range(0, 2));
            it.reg_select = 2'($urandom_range(0, 2));
            if (it.reg_select != REG_MODE && $urandom_range(0, 1))
                it.write_data = 16'($urandom_range(0, 300));
        end
        else if (r < 90)
            it.cmd = 3'($urandom_range(CMD_HBS, CMD_VBE));
        return it;
    endfunction

    task automatic send_item(in_item_t it, bit fixed, out_item_t res);
        int         gap;
        typed_res_t tr;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tr.fixed = fixed;
        tr.res = res;
        typed_q.push_back(tr);
        in_valid <= 1'b1;
        din <= it;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (typed_q.size() > 0 || result_q.size() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] d, logic [3:0] c);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DOT;
        cfg_data <= {1'b0, d};
        @(posedge clk);
        dot_sel = d;
        cfg_index <= CFG_CPI;
        cfg_data <= c;
        @(posedge clk);
        cpi = c;
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        out_item_t  want;
        typed_res_t tr;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                    note_mismatch("unexpected item", dout.read_data, 16'h0000);
                else
                begin
                    want = result_q.pop_front();
                    if (dout.read_data !== want.read_data)
                        note_mismatch("read_data", dout.read_data, want.read_data);
                    if (dout.irq_raise !== want.irq_raise)
                        note_mismatch("irq_raise", {13'b0, dout.irq_raise},
                                      {13'b0, want.irq_raise});
                    if (dout.access_error !== want.access_error)
                        note_mismatch("access_error", {15'b0, dout.access_error},
                                      {15'b0, want.access_error});
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_result(din);
                tr = typed_q.pop_front();
                result_q.push_back(tr.fixed ? tr.res : want);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cyc = 0;
            else
                idle_cyc++;
            if (idle_cyc == IDLE_LIMIT)
            begin
                $display("** three_channel_sync_root_counter_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int gap;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        dir_row_t   rows [$];
        out_item_t  z;
        out_item_t  e;
        logic [2:0] ph_dot [5];
        logic [3:0] ph_cpi [5];
        ph_dot = '{3'd1, 3'd0, 3'd5, 3'd4, 3'd2};
        ph_cpi = '{4'd2, 4'd1, 4'd15, 4'd15, 4'd7};
        z = '0;
        e = '0;
        e.access_error = 1'b1;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        din <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_DOT;
        cfg_data <= '0;
        clear_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{mk(CMD_READ, 2'd0, REG_VALUE, '0, '0), 1, z});
        rows.push_back('{mk(CMD_READ, 2'd1, REG_MODE, '0, '0), 1, z});
        rows.push_back('{mk(CMD_READ, 2'd2, REG_TARGET, '0, '0), 1, z});
        rows.push_back('{mk(CMD_READ, 2'd3, REG_VALUE, '0, '0), 1, e});
        rows.push_back('{mk(CMD_WRITE, 2'd0, 2'd3, 16'hFFFF, '0), 1, e});
        rows.push_back('{in_item_t'('1), 1, z});
        rows.push_back('{mk(CMD_WRITE, 2'd0, REG_MODE, 16'hFFFF, 8'hFF), 1, z});
        rows.push_back('{mk(CMD_READ, 2'd0, REG_MODE, '0, '0), 1,
                         '{read_data: 16'h07FF, irq_raise: '0, access_error: 1'b0}});
        rows.push_back('{mk(CMD_WRITE, 2'd0, REG_MODE, 16'h0100, '0), 1, z});
        rows.push_back('{mk(CMD_WRITE, 2'd0, REG_TARGET, 16'h0005, '0), 1, z});
        rows.push_back('{mk(CMD_WRITE, 2'd1, REG_TARGET, 16'hFFFF, '0), 1, z});
        rows.push_back('{mk(CMD_READ, 2'd1, REG_TARGET, '0, '0), 1,
                         '{read_data: 16'hFFFF, irq_raise: '0, access_error: 1'b0}});
        for (int k = 0; k < 4; k++)
            rows.push_back('{mk(CMD_TICK, '0, '0, '0, 8'hFF), 0, z});
        rows.push_back('{mk(CMD_READ, 2'd0, REG_VALUE, '0, '0), 0, z});
        rows.push_back('{mk(CMD_WRITE, 2'd1, REG_MODE, 16'h0159, '0), 0, z});
        rows.push_back('{mk(CMD_WRITE, 2'd1, REG_TARGET, 16'h0002, '0), 0, z});
        for (int k = 0; k < 3; k++)
            rows.push_back('{mk(CMD_HBS, '0, '0, '0, '0), 0, z});
        rows.push_back('{mk(CMD_HBE, '0, '0, '0, '0), 0, z});
        rows.push_back('{mk(CMD_VBS, '0, '0, '0, '0), 0, z});
        rows.push_back('{mk(CMD_VBE, '0, '0, '0, '0), 0, z});
        rows.push_back('{mk(CMD_WRITE, 2'd2, REG_MODE, 16'h02B0, '0), 0, z});
        rows.push_back('{mk(CMD_WRITE, 2'd2, REG_VALUE, 16'hFFF0, '0), 0, z});
        rows.push_back('{mk(CMD_TICK, '0, '0, '0, 8'h00), 0, z});
        rows.push_back('{mk(CMD_TICK, '0, '0, '0, 8'hFF), 0, z});
        rows.push_back('{mk(CMD_READ, 2'd2, REG_MODE, '0, '0), 0, z});
        foreach (rows[k])
            send_item(rows[k].it, rows[k].fixed, rows[k].res);

        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                drain();
                write_cfg(ph_dot[p], ph_cpi[p]);
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                calm = (p == 1 && k < 40);
                if (p == 2 && k == 30)
                    hold_req = 1;
                send_item(rand_item(), 0, z);
            end
        end
        calm = 0;
        drain();
        if (errors == 0)
            $display("** three_channel_sync_root_counter_core: PASSED **");
        else
            $display("** three_channel_sync_root_counter_core: FAILED **");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/rcnt_pkg.sv
src/rcnt_advance.sv
src/three_channel_sync_root_counter_core.sv
src/rcnt_checker.sv
tb/sv/tb_three_channel_sync_root_counter_core.sv
